@@ hw/rtl/dcbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dcbr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LINE_DEF  = 16384;
  localparam int LINE_BITS_DEF = 24;

  // Fixed geometry of the bank
  localparam int COMB_COUNT = 4;
  localparam int COMB_IDX_W = $clog2(COMB_COUNT);

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int TAIL_W      = 21;
  localparam int PACK_W      = 64;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLED        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WET_TARGET     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WET_STEP       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DAMP_COEF      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COMB_LENGTHS   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COMB_FEEDBACKS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TAIL_SAMPLES   = 3'd6;

  // Register reset values
  localparam logic [COEF_W-1:0] DAMP_COEF_RST    = 16'hFFFF;
  localparam logic [PACK_W-1:0] COMB_LENGTHS_RST = 64'h0001_0001_0001_0001;

  // Request to the shared multiplier
  typedef struct packed {
    logic issue;
    logic wide_shift;
  } mul_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/dcbr_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared multiply and round unit: product register, then a rounding register.
module dcbr_mul
  import dcbr_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mul_ctl_t                            ctl,
  input  logic signed [LINE_BITS:0]           a,
  input  logic        [COEF_W-1:0]            b,
  output logic signed [LINE_BITS+COEF_W+1:0]  result,
  output logic                                result_valid
);

  localparam int A_W  = LINE_BITS + 1;
  localparam int P_W  = A_W + COEF_W + 1;
  localparam int SH_N = COEF_W;
  localparam int SH_W = LINE_BITS - 3;

  localparam logic signed [P_W-1:0] HALF_N = P_W'(1) <<< (SH_N - 1);
  localparam logic signed [P_W-1:0] HALF_W = P_W'(1) <<< (SH_W - 1);

  logic signed [COEF_W:0]  b_s;
  logic signed [P_W-1:0]   prod;
  logic                    wide_q;
  logic                    prod_valid;
  logic        [P_W-1:0]   neg_ext;
  logic signed [P_W-1:0]   bias_n;
  logic signed [P_W-1:0]   bias_w;

  assign b_s = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod   <= a * b_s;
    wide_q <= ctl.wide_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      prod_valid   <= ctl.issue;
      result_valid <= prod_valid;
    end
  end

  // Round to nearest, ties away from zero: add half, less one when negative
  assign neg_ext = P_W'(prod[P_W-1]);
  assign bias_n  = prod + HALF_N - $signed(neg_ext);
  assign bias_w  = prod + HALF_W - $signed(neg_ext);

  always_ff @(posedge clk) begin
    result <= wide_q ? (bias_w >>> SH_W) : (bias_n >>> SH_N);
  end

endmodule

`default_nettype wire

@@ hw/rtl/damped_comb_bank_reverb.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Four parallel lowpass-feedback comb filters turning a mono send sample into
// a stereo wet sample.
// Input stream: s_tdata carries one signed Q1.15 dry sample per word.
// Output stream: m_tdata carries left_wet, right_wet (Q1.15, saturated) and
// the ringing flag, one word per input word, in order.
// Configuration: cfg_wr_en / cfg_index / cfg_data write one register per
// cycle; write only while the block is idle.
// Sequence: an enabled word runs the gain ramp, each comb in turn and the left
// and right output multiplies, then leaves from the done state; the next word
// is taken in idle. All multiplications go through one multiply-and-round
// unit; each comb costs seven sequencer steps (line read, lowpass multiply,
// feedback multiply, line write). A disabled word goes straight to done.
// The delay lines live in one single-port-write, registered-read memory; a
// per-comb fill count stands in for clearing it, so reset needs no sweep.
// Reset loads register defaults; clears cursors, lowpass, wet gain, tail count.
// If the receiver stalls, the finished word holds in the output register and
// the block still takes and works on the next input word, then waits.
module damped_comb_bank_reverb
  import dcbr_pkg::*;
#(
  parameter int MAX_LINE  = MAX_LINE_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // Input stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,   // [15:0] dry_sample
  // Output stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata,   // [15:0] left_wet, [31:16] right_wet,
                                             // [32] ringing, [39:33] zero
  // Configuration write port
  input  logic                    cfg_wr_en,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [PACK_W-1:0]       cfg_data
);

  localparam int CUR_BITS  = $clog2(MAX_LINE);
  localparam int FILL_W    = CUR_BITS + 1;
  localparam int ADDR_W    = COMB_IDX_W + CUR_BITS;
  localparam int MEM_DEPTH = COMB_COUNT << CUR_BITS;
  localparam int A_W       = LINE_BITS + 1;
  localparam int P_W       = A_W + COEF_W + 1;
  localparam int SUM_W     = P_W + 1;
  localparam int QSH       = LINE_BITS - 22;
  localparam int LEN_CMP_W = COEF_W + 1;

  localparam logic signed [SUM_W-1:0] LINE_HI  = (SUM_W'(1) <<< (LINE_BITS - 1)) - 1;
  localparam logic signed [SUM_W-1:0] LINE_LO  = -LINE_HI - 1;
  localparam logic signed [SUM_W-1:0] OUT_HI   = (SUM_W'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0] OUT_LO   = -OUT_HI - 1;
  localparam logic signed [SUM_W-1:0] GAIN_MAX = (SUM_W'(1) <<< COEF_W) - 1;
  localparam logic [COEF_W-1:0]       LEN_MAX  = COEF_W'(MAX_LINE);
  localparam logic [COMB_IDX_W-1:0]   LAST_COMB = COMB_IDX_W'(COMB_COUNT - 1);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_GAIN     = 16'h0002,
    ST_GWAIT    = 16'h0004,
    ST_GAPPLY   = 16'h0008,
    ST_RD       = 16'h0010,
    ST_LPISS    = 16'h0020,
    ST_LPWAIT   = 16'h0040,
    ST_LPAPPLY  = 16'h0080,
    ST_FBISS    = 16'h0100,
    ST_FBWAIT   = 16'h0200,
    ST_WRITE    = 16'h0400,
    ST_OUTL     = 16'h0800,
    ST_OUTR     = 16'h1000,
    ST_CAPL     = 16'h2000,
    ST_CAPR     = 16'h4000,
    ST_DONE     = 16'h8000
  } state_t;

  function automatic logic signed [LINE_BITS-1:0] sat_line(input logic signed [SUM_W-1:0] v);
    if (v > LINE_HI) begin
      return LINE_HI[LINE_BITS-1:0];
    end else if (v < LINE_LO) begin
      return LINE_LO[LINE_BITS-1:0];
    end
    return v[LINE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    if (v > OUT_HI) begin
      return OUT_HI[SAMPLE_W-1:0];
    end else if (v < OUT_LO) begin
      return OUT_LO[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Configuration registers
  logic                 enabled;
  logic [COEF_W-1:0]    wet_target;
  logic [COEF_W-1:0]    wet_step;
  logic [COEF_W-1:0]    damp_coef;
  logic [PACK_W-1:0]    comb_lengths;
  logic [PACK_W-1:0]    comb_feedbacks;
  logic [TAIL_W-1:0]    tail_samples;

  // Filter state
  state_t                      state;
  state_t                      state_next;
  logic [COMB_IDX_W-1:0]       comb_idx;
  logic [CUR_BITS-1:0]         cursor [COMB_COUNT];
  logic [FILL_W-1:0]           fill   [COMB_COUNT];
  logic signed [LINE_BITS-1:0] lp_val [COMB_COUNT];
  logic [COEF_W-1:0]           wet_gain;
  logic [TAIL_W-1:0]           tail_rem;
  logic [TAIL_W-1:0]           tail_next;

  // Delay-line memory
  logic signed [LINE_BITS-1:0] mem [MEM_DEPTH];
  logic signed [LINE_BITS-1:0] mem_q;
  logic [ADDR_W-1:0]           mem_addr;

  // Working registers
  logic signed [SAMPLE_W-1:0]  sample;
  logic signed [LINE_BITS-1:0] quarter;
  logic signed [LINE_BITS-1:0] quarter_calc;
  logic signed [A_W-1:0]       side [2];
  logic                        rd_hit;
  logic signed [SAMPLE_W-1:0]  res_left;
  logic signed [SAMPLE_W-1:0]  res_right;
  logic                        res_ring;

  // Per-comb selections
  logic [CUR_BITS-1:0]         cur;
  logic [FILL_W-1:0]           fill_cur;
  logic [CUR_BITS:0]           cur_inc;
  logic signed [LINE_BITS-1:0] lp_cur;
  logic signed [LINE_BITS-1:0] delayed;
  logic [COEF_W-1:0]           len_raw;
  logic [COEF_W-1:0]           len_eff;
  logic [COEF_W-1:0]           fb_cur;

  // Shared multiplier
  mul_ctl_t                    mul_ctl;
  logic signed [A_W-1:0]       mul_a;
  logic [COEF_W-1:0]           mul_b;
  logic signed [P_W-1:0]       mul_res;
  logic                        mul_valid;

  logic signed [COEF_W:0]      gdiff;
  logic signed [SUM_W-1:0]     gsum;
  logic signed [SUM_W-1:0]     lp_sum;
  logic signed [SUM_W-1:0]     line_sum;
  logic signed [LINE_BITS-1:0] lp_sat;
  logic signed [LINE_BITS-1:0] line_sat;

  logic in_acc;
  logic out_load;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Select the current comb's state and settings
  assign cur      = cursor[comb_idx];
  assign fill_cur = fill[comb_idx];
  assign lp_cur   = lp_val[comb_idx];
  assign cur_inc  = {1'b0, cur} + 1'b1;
  assign len_raw  = comb_lengths[COEF_W*comb_idx +: COEF_W];
  assign fb_cur   = comb_feedbacks[COEF_W*comb_idx +: COEF_W];
  assign mem_addr = {comb_idx, cur};
  assign delayed  = rd_hit ? mem_q : '0;

  // Zero length acts as one; clamp long lines to the memory slice
  always_comb begin
    if (len_raw == '0) begin
      len_eff = COEF_W'(1);
    end else if (len_raw > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_raw;
    end
  end

  // Quarter of the input in line format
  generate
    if (QSH >= 0) begin : g_q_up
      assign quarter_calc = LINE_BITS'(sample) <<< QSH;
    end else begin : g_q_down
      localparam int QR = -QSH;
      localparam logic signed [LINE_BITS-1:0] QHALF = LINE_BITS'(1) <<< (QR - 1);
      logic signed [LINE_BITS-1:0] sx;
      logic [LINE_BITS-1:0]        sneg;
      assign sx   = LINE_BITS'(sample);
      assign sneg = LINE_BITS'(sx[LINE_BITS-1]);
      assign quarter_calc = (sx + QHALF - $signed(sneg)) >>> QR;
    end
  endgenerate

  assign tail_next = (sample != '0) ? tail_samples :
                     (tail_rem != '0) ? tail_rem - 1'b1 : '0;

  assign gdiff    = $signed({1'b0, wet_target}) - $signed({1'b0, wet_gain});
  assign gsum     = SUM_W'($signed({1'b0, wet_gain})) + SUM_W'(mul_res);
  assign lp_sum   = SUM_W'(lp_cur) + SUM_W'(mul_res);
  assign line_sum = SUM_W'(quarter) + SUM_W'(mul_res);
  assign lp_sat   = sat_line(lp_sum);
  assign line_sat = sat_line(line_sum);

  // Operand selection for the shared multiplier
  always_comb begin
    mul_ctl.issue      = 1'b0;
    mul_ctl.wide_shift = 1'b0;
    mul_a              = '0;
    mul_b              = '0;
    case (state)
      ST_GAIN: begin
        mul_ctl.issue = 1'b1;
        mul_a         = A_W'(gdiff);
        mul_b         = wet_step;
      end
      ST_LPISS: begin
        mul_ctl.issue = 1'b1;
        mul_a         = A_W'(delayed) - A_W'(lp_cur);
        mul_b         = damp_coef;
      end
      ST_FBISS: begin
        mul_ctl.issue = 1'b1;
        mul_a         = A_W'(lp_cur);
        mul_b         = fb_cur;
      end
      ST_OUTL: begin
        mul_ctl.issue      = 1'b1;
        mul_ctl.wide_shift = 1'b1;
        mul_a              = side[0];
        mul_b              = wet_gain;
      end
      ST_OUTR: begin
        mul_ctl.issue      = 1'b1;
        mul_ctl.wide_shift = 1'b1;
        mul_a              = side[1];
        mul_b              = wet_gain;
      end
      default: begin
        mul_ctl.issue = 1'b0;
      end
    endcase
  end

  dcbr_mul #(
    .LINE_BITS (LINE_BITS)
  ) u_mul (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mul_ctl),
    .a            (mul_a),
    .b            (mul_b),
    .result       (mul_res),
    .result_valid (mul_valid)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = enabled ? ST_GAIN : ST_DONE;
        end
      end
      ST_GAIN:    state_next = ST_GWAIT;
      ST_GWAIT:   state_next = ST_GAPPLY;
      ST_GAPPLY:  state_next = ST_RD;
      ST_RD:      state_next = ST_LPISS;
      ST_LPISS:   state_next = ST_LPWAIT;
      ST_LPWAIT:  state_next = ST_LPAPPLY;
      ST_LPAPPLY: state_next = ST_FBISS;
      ST_FBISS:   state_next = ST_FBWAIT;
      ST_FBWAIT:  state_next = ST_WRITE;
      ST_WRITE:   state_next = (comb_idx == LAST_COMB) ? ST_OUTL : ST_RD;
      ST_OUTL:    state_next = ST_OUTR;
      ST_OUTR:    state_next = ST_CAPL;
      ST_CAPL:    state_next = ST_CAPR;
      ST_CAPR:    state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control state and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      enabled        <= 1'b0;
      wet_target     <= '0;
      wet_step       <= '0;
      damp_coef      <= DAMP_COEF_RST;
      comb_lengths   <= COMB_LENGTHS_RST;
      comb_feedbacks <= '0;
      tail_samples   <= '0;
      comb_idx       <= '0;
      wet_gain       <= '0;
      tail_rem       <= '0;
      for (int i = 0; i < COMB_COUNT; i++) begin
        cursor[i] <= '0;
        fill[i]   <= '0;
        lp_val[i] <= '0;
      end
    end else begin
      state <= state_next;

      // Hold the finished word until taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENABLED:        enabled        <= cfg_data[0];
          REG_WET_TARGET:     wet_target     <= cfg_data[COEF_W-1:0];
          REG_WET_STEP:       wet_step       <= cfg_data[COEF_W-1:0];
          REG_DAMP_COEF:      damp_coef      <= cfg_data[COEF_W-1:0];
          REG_COMB_LENGTHS:   comb_lengths   <= cfg_data;
          REG_COMB_FEEDBACKS: comb_feedbacks <= cfg_data;
          REG_TAIL_SAMPLES:   tail_samples   <= cfg_data[TAIL_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == ST_GAIN) begin
        tail_rem <= tail_next;
        comb_idx <= '0;
      end

      // Ramp the wet gain and clamp it to the Q0.16 range
      if (state == ST_GAPPLY) begin
        if (gsum < 0) begin
          wet_gain <= '0;
        end else if (gsum > GAIN_MAX) begin
          wet_gain <= GAIN_MAX[COEF_W-1:0];
        end else begin
          wet_gain <= gsum[COEF_W-1:0];
        end
      end

      if (state == ST_LPAPPLY) begin
        lp_val[comb_idx] <= lp_sat;
      end

      // Advance the cursor, grow the fill count, step to the next comb
      if (state == ST_WRITE) begin
        if (LEN_CMP_W'(cur_inc) >= LEN_CMP_W'(len_eff)) begin
          cursor[comb_idx] <= '0;
        end else begin
          cursor[comb_idx] <= cur_inc[CUR_BITS-1:0];
        end
        if ({1'b0, cur} == fill_cur) begin
          fill[comb_idx] <= fill_cur + 1'b1;
        end
        comb_idx <= comb_idx + 1'b1;
      end
    end
  end

  // Delay-line memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      mem[mem_addr] <= line_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      mem_q  <= mem[mem_addr];
      rd_hit <= ({1'b0, cur} < fill_cur);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample    <= $signed(s_tdata);
      res_left  <= '0;
      res_right <= '0;
      res_ring  <= 1'b0;
    end
    if (state == ST_GAIN) begin
      quarter  <= quarter_calc;
      side[0]  <= '0;
      side[1]  <= '0;
      res_ring <= (tail_next != '0);
    end
    if (state == ST_LPISS) begin
      side[comb_idx[0]] <= side[comb_idx[0]] + A_W'(delayed);
    end
    if (state == ST_CAPL) begin
      res_left <= sat_out(SUM_W'(mul_res));
    end
    if (state == ST_CAPR) begin
      res_right <= sat_out(SUM_W'(mul_res));
    end
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({res_ring, res_right, res_left});
    end
  end

`ifndef SYNTHESIS
  // Multiplier results land exactly in the steps that consume them
  a_mul_lands: assert property (@(posedge clk) disable iff (rst)
    mul_valid |-> (state == ST_GAPPLY || state == ST_LPAPPLY || state == ST_WRITE ||
                   state == ST_CAPL || state == ST_CAPR))
    else $error("multiplier result outside a consuming step");

  a_mul_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GAPPLY || state == ST_LPAPPLY || state == ST_WRITE ||
     state == ST_CAPL || state == ST_CAPR) |-> mul_valid)
    else $error("consuming step without a multiplier result");

  a_fill_covers: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor[comb_idx]} <= fill[comb_idx])
    else $error("cursor ahead of the written part of its line");

  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && (!m_tvalid || m_tready) |=> m_tvalid && (state == ST_IDLE))
    else $error("finished word not presented");
`endif

endmodule

`default_nettype wire
